// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer scheduler package
// Shared types, codes and constants for the timer scheduler core.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [1:0] OP_CREATE_PERIODIC = 2'd0;
  localparam logic [1:0] OP_CREATE_ONE_SHOT = 2'd1;
  localparam logic [1:0] OP_DELETE          = 2'd2;
  localparam logic [1:0] OP_POLL            = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_USED  = 2'd2;
  localparam logic [1:0] ST_NO_EXPIRE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUB,
    S_SCAN,
    S_DIV,
    S_UPD,
    S_NEXT,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic create;     // write a new timer in the free slot
    logic delete_op;  // free the named slot
    logic sub_step;   // subtract elapsed ticks from one slot
    logic scan_clr;   // restart the minimum search
    logic scan_step;  // compare one slot into the minimum
    logic div_start;  // set up the missed count divide
    logic div_step;   // one restoring divide step
    logic fire;       // reload or free the fired slot, latch fire fields
    logic out_load;   // put the result into the output register
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       idx_last;  // scan index on the last slot
    logic       div_done;
    logic       any_used;
    logic       expired;   // best remaining time at or below zero
  } sts_t;

endpackage

// ===== rtl/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Periodic timer scheduler controller
// Sequences create, delete and poll operations over the datapath.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_busy,
  input  pts_pkg::sts_t sts,
  output pts_pkg::cmd_t cmd
);
  import pts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SUB;
        end
      end
      S_SUB: begin
        case (sts.op)
          OP_CREATE_PERIODIC, OP_CREATE_ONE_SHOT: begin
            cmd.create = 1'b1;
            cmd.scan_clr = 1'b1;
            state_next = S_NEXT;
          end
          OP_DELETE: begin
            cmd.delete_op = 1'b1;
            cmd.scan_clr = 1'b1;
            state_next = S_NEXT;
          end
          default: begin
            cmd.sub_step = 1'b1;
            if (sts.idx_last) begin
              cmd.scan_clr = 1'b1;
              state_next = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) state_next = S_DIV;
      end
      S_DIV: begin
        // Minimum is final here; decide whether a timer fires.
        if (sts.any_used && sts.expired) begin
          cmd.div_start = 1'b1;
          state_next = S_UPD;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_UPD: begin
        if (sts.div_done) begin
          cmd.fire = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = S_NEXT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_NEXT: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/pts_datapath.sv =====
// ----------------------------------------------------------------------------
// Periodic timer scheduler datapath
// Slot table, serial minimum search, serial divider and result register.
// ----------------------------------------------------------------------------
module pts_datapath #(
  parameter int NUM_TIMERS = pts_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = pts_pkg::TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  pts_pkg::cmd_t cmd,
  output pts_pkg::sts_t sts,
  input  logic [85:0]   in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [87:0]   out_data
);
  import pts_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int RW = TIME_WIDTH + 1;
  localparam int DW = TIME_WIDTH + 2;
  localparam int CW = $clog2(DW + 1);
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;
  localparam logic signed [RW-1:0] TMIN = {1'b1, {TIME_WIDTH{1'b0}}};

  logic [NUM_TIMERS-1:0] used;
  logic [NUM_TIMERS-1:0] one_shot;
  logic [TIME_WIDTH-1:0] period [NUM_TIMERS];
  logic signed [RW-1:0]  remaining [NUM_TIMERS];
  logic [15:0]           tag [NUM_TIMERS];

  logic [1:0]            op;
  logic [31:0]           in_period, in_elapsed;
  logic [15:0]           in_tag;
  logic [3:0]            in_slot;
  logic [IW-1:0]         idx;
  logic                  best_any;
  logic [IW-1:0]         best;
  logic signed [RW-1:0]  best_rem;
  logic [1:0]            r_status;
  logic [3:0]            r_idx;
  logic                  r_fired;
  logic [15:0]           r_tag;
  logic [31:0]           r_missed;
  logic [DW-1:0]         num, rem_acc;
  logic [TIME_WIDTH-1:0] dvs;
  logic [CW-1:0]         div_cnt;

  // Free slot search, input clamps, subtract limit and divide trial.
  logic                  free_found;
  logic [IW-1:0]         free_idx;
  logic [TIME_WIDTH-1:0] per_c, ela_c;
  logic signed [RW:0]    sub_lim;
  logic [DW:0]           trial;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
    if (TIME_WIDTH < 32 && (in_period >> TIME_WIDTH) != 32'd0) per_c = TMAX;
    else per_c = TIME_WIDTH'(in_period);
    if (per_c == '0) per_c = TIME_WIDTH'(1);
    if (TIME_WIDTH < 32 && (in_elapsed >> TIME_WIDTH) != 32'd0) ela_c = TMAX;
    else ela_c = TIME_WIDTH'(in_elapsed);
    sub_lim = {remaining[idx][RW-1], remaining[idx]} - $signed({2'b00, ela_c});
    trial = {rem_acc, num[DW-1]} - {{2{1'b0}}, dvs};
  end

  assign sts.op       = op;
  assign sts.idx_last = (idx == IW'(NUM_TIMERS - 1));
  assign sts.div_done = (div_cnt == '0);
  assign sts.any_used = best_any;
  assign sts.expired  = (best_rem <= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      div_cnt   <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        op         <= in_data[1:0];
        in_period  <= in_data[33:2];
        in_tag     <= in_data[49:34];
        in_slot    <= in_data[53:50];
        in_elapsed <= in_data[85:54];
        idx        <= '0;
        r_fired    <= 1'b0;
        r_tag      <= '0;
        r_missed   <= '0;
        r_idx      <= '0;
      end
      if (cmd.create) begin
        if (free_found) begin
          used[free_idx]      <= 1'b1;
          one_shot[free_idx]  <= (op == OP_CREATE_ONE_SHOT);
          period[free_idx]    <= per_c;
          remaining[free_idx] <= $signed({1'b0, per_c});
          tag[free_idx]       <= in_tag;
          r_status            <= ST_DONE;
          r_idx               <= 4'(free_idx);
        end else begin
          r_status <= ST_FULL;
        end
      end
      if (cmd.delete_op) begin
        r_idx <= in_slot;
        if ({28'd0, in_slot} >= 32'(NUM_TIMERS) || !used[IW'(in_slot)]) begin
          r_status <= ST_NOT_USED;
        end else begin
          used[IW'(in_slot)] <= 1'b0;
          r_status <= ST_DONE;
        end
      end
      if (cmd.sub_step) begin
        r_status <= ST_NO_EXPIRE;
        // An empty table drops the elapsed ticks; otherwise every used slot moves.
        if (used[idx] && used != '0) begin
          if (sub_lim < $signed({TMIN[RW-1], TMIN})) remaining[idx] <= TMIN;
          else remaining[idx] <= RW'(sub_lim);
        end
        idx <= sts.idx_last ? '0 : idx + IW'(1);
      end
      if (cmd.scan_clr) begin
        idx      <= '0;
        best_any <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (used[idx] && (!best_any || remaining[idx] < best_rem)) begin
          best_any <= 1'b1;
          best     <= idx;
          best_rem <= remaining[idx];
        end
        idx <= sts.idx_last ? '0 : idx + IW'(1);
      end
      if (cmd.div_start) begin
        // Dividend is period minus remaining, always positive here.
        num     <= DW'({1'b0, period[best]}) - DW'(best_rem);
        dvs     <= period[best];
        rem_acc <= '0;
        div_cnt <= CW'(DW);
      end
      if (cmd.div_step) begin
        if (!trial[DW]) begin
          rem_acc <= DW'(trial);
          num     <= {num[DW-2:0], 1'b1};
        end else begin
          rem_acc <= {rem_acc[DW-2:0], num[DW-1]};
          num     <= {num[DW-2:0], 1'b0};
        end
        div_cnt <= div_cnt - CW'(1);
      end
      if (cmd.fire) begin
        r_status <= ST_DONE;
        r_fired  <= 1'b1;
        r_idx    <= 4'(best);
        r_tag    <= tag[best];
        r_missed <= (DW > 32 && (num >> 32) != '0) ? 32'hFFFF_FFFF : 32'(num);
        if (one_shot[best]) used[best] <= 1'b0;
        else remaining[best] <= $signed({1'b0, period[best]});
      end
      if (cmd.out_load) begin
        out_valid       <= 1'b1;
        out_data[1:0]   <= r_status;
        out_data[5:2]   <= r_idx;
        out_data[6]     <= r_fired;
        out_data[22:7]  <= r_tag;
        out_data[54:23] <= r_missed;
        if (!best_any) out_data[87:55] <= '1;
        else if (best_rem <= 0) out_data[87:55] <= '0;
        else out_data[87:55] <= 33'(best_rem);
      end
    end
  end

endmodule

// ===== rtl/periodic_timer_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Periodic timer scheduler core
// Timer slot table with create, delete and poll operations.
// ----------------------------------------------------------------------------
// One word in gives one word out. A create or delete makes one pass of the
// serial minimum search that finds the next timeout. A poll makes the serial
// subtract pass and two passes of the serial minimum search, and runs the
// restoring divider for the missed count when a timer fires. A new result
// is held back while the previous one stalls in the output register. A result
// waits in the output register while the next word is already being taken.
module periodic_timer_scheduler_core #(
  parameter int NUM_TIMERS = pts_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = pts_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation, timer_period, target_tag, timer_slot, elapsed_ticks, zero pad
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, slot_index, fired, fired_tag, missed_count, next_timeout
  output logic [87:0] m_tdata
);
  import pts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_busy(m_tvalid && !m_tready), .sts(sts), .cmd(cmd)
  );

  pts_datapath #(.NUM_TIMERS(NUM_TIMERS), .TIME_WIDTH(TIME_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_data(s_tdata[85:0]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

endmodule

// ===== rtl/pts_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic timer scheduler checker
// Port-level assertions bound to the core.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata
);
  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A fired result always reports status done.
  a_fire: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] |-> m_tdata[1:0] == 2'd0)
    else $error("fired without done status");

  // Nothing fired means no tag and no count.
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[6] |-> m_tdata[54:7] == '0)
    else $error("fire fields set without fire");

  // Accepting a word keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("took two words back to back");
endmodule

bind periodic_timer_scheduler_core pts_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
